// File: src/pts_pkg.sv
// shared types, constants and the arctangent table for the pan/tilt slew block
// no dependencies; used by pts_cordic, pts_div and pan_tilt_stepped_slew
`default_nettype none
package pts_pkg;

    localparam int CORDIC_ITER = 24;
    localparam int CNT_W = $clog2(CORDIC_ITER + 1);
    localparam int XY_W = 45;
    localparam int Z_W = 34;
    localparam int DIVN_W = 50;
    localparam int DIVD_W = 35;
    localparam int DCNT_W = $clog2(DIVN_W + 1);

    localparam logic [11:0] BRG_FULL = 12'd3600;
    localparam logic [16:0] ELEV_MAX = 17'd90000;
    localparam logic [16:0] ELEV_RESET = 17'd250;
    localparam logic [13:0] MAST_RESET = 14'd1000;
    localparam logic [31:0] RANGE_SAT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                    start;
        logic                    vec;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [Z_W-1:0]   z;
    } cordic_cmd_t;

    typedef struct packed {
        logic                    done;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [Z_W-1:0]   z;
    } cordic_res_t;

    typedef struct packed {
        logic                start;
        logic [DIVN_W-1:0]   dividend;
        logic [DIVD_W-1:0]   divisor;
    } div_cmd_t;

    typedef struct packed {
        logic                done;
        logic [DIVN_W-1:0]   quotient;
    } div_res_t;

    // atan(2^-i) in units of 360/2^32 deg
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] i);
        logic signed [Z_W-1:0] v;
        begin
            case (i)
                5'd0:  v = 34'sd536870912;
                5'd1:  v = 34'sd316933406;
                5'd2:  v = 34'sd167458907;
                5'd3:  v = 34'sd85004756;
                5'd4:  v = 34'sd42667331;
                5'd5:  v = 34'sd21354465;
                5'd6:  v = 34'sd10679838;
                5'd7:  v = 34'sd5340245;
                5'd8:  v = 34'sd2670163;
                5'd9:  v = 34'sd1335087;
                5'd10: v = 34'sd667544;
                5'd11: v = 34'sd333772;
                5'd12: v = 34'sd166886;
                5'd13: v = 34'sd83443;
                5'd14: v = 34'sd41722;
                5'd15: v = 34'sd20861;
                5'd16: v = 34'sd10430;
                5'd17: v = 34'sd5215;
                5'd18: v = 34'sd2608;
                5'd19: v = 34'sd1304;
                5'd20: v = 34'sd652;
                5'd21: v = 34'sd326;
                5'd22: v = 34'sd163;
                5'd23: v = 34'sd81;
                5'd24: v = 34'sd41;
                5'd25: v = 34'sd20;
                5'd26: v = 34'sd10;
                5'd27: v = 34'sd5;
                5'd28: v = 34'sd3;
                5'd29: v = 34'sd1;
                5'd30: v = 34'sd1;
                default: v = 34'sd0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

// File: src/pts_cordic.sv
// iterative cordic unit, rotation and vectoring, one micro-rotation per cycle
// depends on pts_pkg
`default_nettype none
module pts_cordic (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pts_pkg::cordic_cmd_t cmd,
    output pts_pkg::cordic_res_t      res
);
    import pts_pkg::*;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_NORM = 2'd1;
    localparam logic [1:0] C_ITER = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   done_reg, done_next;
    logic                   vec_reg, vec_next;
    logic signed [XY_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;

    logic [4:0]             idx;
    logic signed [XY_W-1:0] sx, sy;
    logic signed [Z_W-1:0]  ang;
    logic                   ccw;
    logic                   big;

    // arithmetic shift that truncates toward zero
    function automatic logic signed [XY_W-1:0] shr_tz(
        input logic signed [XY_W-1:0] v, input logic [4:0] s);
        logic [XY_W-1:0] m;
        begin
            m = v[XY_W-1] ? XY_W'(-v) : XY_W'(v);
            m = m >> s;
            return v[XY_W-1] ? -$signed(m) : $signed(m);
        end
    endfunction

    assign idx = 5'(cnt_reg);
    assign sx  = shr_tz(x_reg, idx);
    assign sy  = shr_tz(y_reg, idx);
    assign ang = atan_entry(idx);
    assign ccw = vec_reg ? !(y_reg > 0) : (z_reg >= 0);
    assign big = (|x_reg[43:40]) || (|y_reg[43:40]);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        vec_next   = vec_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (cmd.start)
                begin
                    x_next     = cmd.x;
                    y_next     = cmd.y;
                    z_next     = cmd.z;
                    vec_next   = cmd.vec;
                    cnt_next   = '0;
                    state_next = cmd.vec ? C_NORM : C_ITER;
                end
            end
            C_NORM:
            begin
                // scale operands up until the larger one reaches 2^40
                if (big)
                begin
                    state_next = C_ITER;
                end
                else
                begin
                    x_next = x_reg <<< 1;
                    y_next = y_reg <<< 1;
                end
            end
            C_ITER:
            begin
                if (ccw)
                begin
                    x_next = x_reg - sy;
                    y_next = y_reg + sx;
                    z_next = z_reg - ang;
                end
                else
                begin
                    x_next = x_reg + sy;
                    y_next = y_reg - sx;
                    z_next = z_reg + ang;
                end
                if (cnt_reg == CNT_W'(CORDIC_ITER - 1))
                begin
                    state_next = C_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        vec_reg <= vec_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
    end

    assign res.done = done_reg;
    assign res.x    = x_reg;
    assign res.y    = y_reg;
    assign res.z    = z_reg;

endmodule
`default_nettype wire

// File: src/pts_div.sv
// restoring divider, one quotient bit per cycle
// depends on pts_pkg
`default_nettype none
module pts_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pts_pkg::div_cmd_t cmd,
    output pts_pkg::div_res_t      res
);
    import pts_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DCNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIVD_W-1:0]   rem_reg, rem_next;
    logic [DIVD_W-1:0]   dvs_reg, dvs_next;
    logic [DIVN_W-1:0]   quo_reg, quo_next;
    logic [DIVD_W:0]     rem_sh;
    logic                fits;

    assign rem_sh = {rem_reg, quo_reg[DIVN_W-1]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (!busy_reg)
        begin
            if (cmd.start)
            begin
                busy_next = 1'b1;
                cnt_next  = '0;
                rem_next  = '0;
                dvs_next  = cmd.divisor;
                quo_next  = cmd.dividend;
            end
        end
        else
        begin
            rem_next = fits ? DIVD_W'(rem_sh - {1'b0, dvs_reg}) : DIVD_W'(rem_sh);
            quo_next = {quo_reg[DIVN_W-2:0], fits};
            if (cnt_reg == DCNT_W'(DIVN_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign res.done     = done_reg;
    assign res.quotient = quo_reg;

endmodule
`default_nettype wire

// File: src/pan_tilt_stepped_slew.sv
// top level of the pan/tilt slew block: apb registers, sequencer, output register
// depends on pts_pkg, pts_cordic, pts_div
`default_nettype none
// Each item runs through one shared 24-step cordic unit and one 50-bit
// restoring divider that are used in turn. An angle-to-range conversion
// costs up to two divides and one cordic pass; the range-to-angle step costs
// one cordic pass after its operands are normalized. A load or an
// instant-mode item does one conversion; a stepped tick does up to three
// conversions and one arctangent. The input is not ready while an item is
// in progress; a finished result waits in the output register while the
// next item starts.
module pan_tilt_stepped_slew (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // apb configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // req_bearing[11:0], req_elevation[28:12]
    input  wire logic [0:0]  s_tuser,   // func[0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata    // actual_bearing[11:0], actual_elevation[28:12],
                                        // actual_range[60:29], moved[61]
);
    import pts_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_EZ_GO  = 4'd1;
    localparam logic [3:0] ST_EZ_WT  = 4'd2;
    localparam logic [3:0] ST_ER_GO  = 4'd3;
    localparam logic [3:0] ST_ER_WT  = 4'd4;
    localparam logic [3:0] ST_EM     = 4'd5;
    localparam logic [3:0] ST_ED_GO  = 4'd6;
    localparam logic [3:0] ST_ED_WT  = 4'd7;
    localparam logic [3:0] ST_ERET   = 4'd8;
    localparam logic [3:0] ST_DECIDE = 4'd9;
    localparam logic [3:0] ST_RV_GO  = 4'd10;
    localparam logic [3:0] ST_RV_WT  = 4'd11;
    localparam logic [3:0] ST_RM     = 4'd12;
    localparam logic [3:0] ST_RE     = 4'd13;
    localparam logic [3:0] ST_OUT    = 4'd14;

    localparam logic [1:0] PH_REQ = 2'd0;
    localparam logic [1:0] PH_NOW = 2'd1;
    localparam logic [1:0] PH_FIN = 2'd2;

    localparam logic       REG_MAST    = 1'b0;
    localparam logic       REG_INSTANT = 1'b1;

    // configuration
    logic [13:0] mast_reg;
    logic        instant_reg;
    logic        cfg_wr;
    logic [13:0] mast_cm;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign mast_cm = (mast_reg == 14'd0) ? 14'd1 : mast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mast_reg    <= MAST_RESET;
            instant_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_MAST:    mast_reg    <= pwdata[13:0];
                REG_INSTANT: instant_reg <= pwdata[0];
                default:     mast_reg    <= mast_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MAST:    prdata = {18'd0, mast_reg};
            REG_INSTANT: prdata = {31'd0, instant_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // shared units
    cordic_cmd_t c_cmd;
    cordic_res_t c_res;
    div_cmd_t    d_cmd;
    div_res_t    d_res;

    pts_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (c_cmd),
        .res   (c_res)
    );

    pts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (d_cmd),
        .res   (d_res)
    );

    // sequencer state
    logic [3:0]  state_reg, state_next;
    logic [1:0]  ph_reg, ph_next;
    logic [11:0] bearing_reg, bearing_next;
    logic [16:0] elev_reg, elev_next;
    logic        mvalid_reg, mvalid_next;

    // payload
    logic [63:0] mdata_reg, mdata_next;
    logic [11:0] nb_reg, nb_next;
    logic [16:0] ne_reg, ne_next;
    logic [16:0] reqe_reg, reqe_next;
    logic [16:0] earg_reg, earg_next;
    logic [31:0] rr_reg, rr_next;
    logic [31:0] rng_reg, rng_next;
    logic [44:0] num_reg, num_next;
    logic [34:0] den_reg, den_next;
    logic [32:0] nr_reg, nr_next;
    logic [49:0] prod_reg, prod_next;

    // input fields
    logic [11:0] b_in, b_fix;
    logic [16:0] e_in, e_fix;
    logic        func;

    assign b_in = s_tdata[11:0];
    assign e_in = s_tdata[28:12];
    assign func = s_tuser[0];
    assign b_fix = (b_in >= BRG_FULL) ? b_in - BRG_FULL : b_in;
    assign e_fix = (e_in == 17'd0) ? 17'd1 : ((e_in > ELEV_MAX) ? ELEV_MAX : e_in);

    // bearing step, shorter way round
    logic [12:0] bsum, d2;
    logic [11:0] d1, bd, bs, b_step;
    logic [12:0] bup, bdn;
    logic        bdown;

    always_comb
    begin
        bsum  = {1'b0, b_fix} + {1'b0, BRG_FULL} - {1'b0, bearing_reg};
        d1    = (bsum >= {1'b0, BRG_FULL}) ? 12'(bsum - {1'b0, BRG_FULL}) : bsum[11:0];
        d2    = {1'b0, BRG_FULL} - {1'b0, d1};
        bdown = {1'b0, d1} > d2;
        bd    = bdown ? d2[11:0] : d1;
        if (bd > 12'd500)
            bs = 12'd100;
        else if (bd > 12'd250)
            bs = 12'd50;
        else if (bd > 12'd50)
            bs = 12'd10;
        else
            bs = bd;
        bup = {1'b0, bearing_reg} + {1'b0, bs};
        bdn = {1'b0, bearing_reg} + {1'b0, BRG_FULL} - {1'b0, bs};
        if (bdown)
            b_step = (bdn >= {1'b0, BRG_FULL}) ? 12'(bdn - {1'b0, BRG_FULL}) : bdn[11:0];
        else
            b_step = (bup >= {1'b0, BRG_FULL}) ? 12'(bup - {1'b0, BRG_FULL}) : bup[11:0];
    end

    // range gap and step
    logic [31:0] gap;
    logic [10:0] rs;
    logic        rfar;

    always_comb
    begin
        rfar = rr_reg > rng_reg;
        gap  = rfar ? rr_reg - rng_reg : rng_reg - rr_reg;
        if (gap > 32'd5000)
            rs = 11'd1000;
        else if (gap > 32'd1000)
            rs = 11'd100;
        else
            rs = 11'd20;
    end

    // cordic operands
    logic signed [XY_W-1:0] cx, cy;
    logic [30:0]            zc;
    logic [50:0]            esum;
    logic [18:0]            ecalc;
    logic [16:0]            eclamp, eadj;
    logic [36:0]            nr10;

    assign cx = c_res.x;
    assign cy = c_res.y;
    assign nr10 = {1'b0, nr_reg, 3'b000} + {3'b000, nr_reg, 1'b0};

    always_comb
    begin
        c_cmd.start = (state_reg == ST_ER_GO) || (state_reg == ST_RV_GO);
        c_cmd.vec   = (state_reg == ST_RV_GO);
        if (state_reg == ST_RV_GO)
        begin
            c_cmd.x = XY_W'(nr10);
            c_cmd.y = XY_W'(mast_cm);
            c_cmd.z = '0;
        end
        else
        begin
            c_cmd.x = XY_W'(64'd1 << 30);
            c_cmd.y = '0;
            c_cmd.z = Z_W'(d_res.quotient[33:0]);
        end
    end

    always_comb
    begin
        d_cmd.start = (state_reg == ST_EZ_GO) || (state_reg == ST_ED_GO);
        if (state_reg == ST_ED_GO)
        begin
            d_cmd.dividend = 50'(num_reg) + 50'(den_reg >> 1);
            d_cmd.divisor  = den_reg;
        end
        else
        begin
            d_cmd.dividend = {1'b0, earg_reg, 32'd0} + 50'd180000;
            d_cmd.divisor  = 35'd360000;
        end
    end

    // arctangent result back to millidegrees, then the no-progress and overshoot rules
    always_comb
    begin
        if (c_res.z < 0)
            zc = '0;
        else if (c_res.z > Z_W'(64'd1 << 30))
            zc = 31'h4000_0000;
        else
            zc = c_res.z[30:0];
        esum  = {1'b0, prod_reg} + 51'h8000_0000;
        ecalc = esum[50:32];
        if (ecalc == 19'd0)
            eclamp = 17'd1;
        else if (ecalc > 19'(ELEV_MAX))
            eclamp = ELEV_MAX;
        else
            eclamp = ecalc[16:0];
        eadj = eclamp;
        if (eadj == elev_reg)
            eadj = (reqe_reg > elev_reg) ? elev_reg + 17'd1 : elev_reg - 17'd1;
        if (reqe_reg > elev_reg && eadj > reqe_reg)
            eadj = reqe_reg;
        if (reqe_reg < elev_reg && eadj < reqe_reg)
            eadj = reqe_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        ph_next      = ph_reg;
        bearing_next = bearing_reg;
        elev_next    = elev_reg;
        mvalid_next  = mvalid_reg;
        mdata_next   = mdata_reg;
        nb_next      = nb_reg;
        ne_next      = ne_reg;
        reqe_next    = reqe_reg;
        earg_next    = earg_reg;
        rr_next      = rr_reg;
        rng_next     = rng_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        nr_next      = nr_reg;
        prod_next    = prod_reg;

        if (mvalid_reg && m_tready)
            mvalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    reqe_next  = e_fix;
                    state_next = ST_EZ_GO;
                    if (func || instant_reg)
                    begin
                        nb_next   = b_fix;
                        ne_next   = e_fix;
                        earg_next = e_fix;
                        ph_next   = PH_FIN;
                    end
                    else if (e_fix == elev_reg)
                    begin
                        nb_next   = b_step;
                        ne_next   = elev_reg;
                        earg_next = elev_reg;
                        ph_next   = PH_FIN;
                    end
                    else
                    begin
                        nb_next   = b_step;
                        earg_next = e_fix;
                        ph_next   = PH_REQ;
                    end
                end
            end
            ST_EZ_GO: state_next = ST_EZ_WT;
            ST_EZ_WT:
            begin
                if (d_res.done)
                    state_next = ST_ER_GO;
            end
            ST_ER_GO: state_next = ST_ER_WT;
            ST_ER_WT:
            begin
                if (c_res.done)
                    state_next = ST_EM;
            end
            ST_EM:
            begin
                if (cy <= 0)
                begin
                    rng_next   = RANGE_SAT;
                    state_next = ST_ERET;
                end
                else if (cx <= 0)
                begin
                    rng_next   = '0;
                    state_next = ST_ERET;
                end
                else
                begin
                    num_next   = 45'(mast_cm) * 45'(cx[30:0]);
                    den_next   = {cy[31:0], 3'b000} + {2'b00, cy[31:0], 1'b0};
                    state_next = ST_ED_GO;
                end
            end
            ST_ED_GO: state_next = ST_ED_WT;
            ST_ED_WT:
            begin
                if (d_res.done)
                begin
                    rng_next   = (|d_res.quotient[49:32]) ? RANGE_SAT : d_res.quotient[31:0];
                    state_next = ST_ERET;
                end
            end
            ST_ERET:
            begin
                case (ph_reg)
                    PH_REQ:
                    begin
                        rr_next    = rng_reg;
                        earg_next  = elev_reg;
                        ph_next    = PH_NOW;
                        state_next = ST_EZ_GO;
                    end
                    PH_NOW:  state_next = ST_DECIDE;
                    default: state_next = ST_OUT;
                endcase
            end
            ST_DECIDE:
            begin
                if (gap <= 32'd200)
                begin
                    ne_next    = reqe_reg;
                    earg_next  = reqe_reg;
                    ph_next    = PH_FIN;
                    state_next = ST_EZ_GO;
                end
                else
                begin
                    nr_next    = rfar ? {1'b0, rng_reg} + 33'(rs) : {1'b0, rng_reg} - 33'(rs);
                    state_next = ST_RV_GO;
                end
            end
            ST_RV_GO: state_next = ST_RV_WT;
            ST_RV_WT:
            begin
                if (c_res.done)
                    state_next = ST_RM;
            end
            ST_RM:
            begin
                prod_next  = 50'(zc) * 50'd360000;
                state_next = ST_RE;
            end
            ST_RE:
            begin
                ne_next    = eadj;
                earg_next  = eadj;
                ph_next    = PH_FIN;
                state_next = ST_EZ_GO;
            end
            ST_OUT:
            begin
                // result register must be free before this transfer is loaded
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next  = 1'b1;
                    mdata_next   = {2'b00,
                                    (nb_reg != bearing_reg) || (ne_reg != elev_reg),
                                    rng_reg, ne_reg, nb_reg};
                    bearing_next = nb_reg;
                    elev_next    = ne_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ph_reg      <= PH_REQ;
            bearing_reg <= 12'd0;
            elev_reg    <= ELEV_RESET;
            mvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ph_reg      <= ph_next;
            bearing_reg <= bearing_next;
            elev_reg    <= elev_next;
            mvalid_reg  <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mdata_reg <= mdata_next;
        nb_reg    <= nb_next;
        ne_reg    <= ne_next;
        reqe_reg  <= reqe_next;
        earg_reg  <= earg_next;
        rr_reg    <= rr_next;
        rng_reg   <= rng_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        nr_reg    <= nr_next;
        prod_reg  <= prod_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    // an accepted item keeps the input closed for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");

    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[11:0] < BRG_FULL))
        else $error("bearing out of range");

    a_elev_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[28:12] != 17'd0 && m_tdata[28:12] <= ELEV_MAX))
        else $error("elevation out of range");

endmodule
`default_nettype wire

// File: test/tb_pts_defs.sv
// register addresses and item kinds shared by the pan/tilt slew testbench files
// no dependencies
`timescale 1ns / 100ps
package tb_pts_defs;

    localparam logic [2:0] REG_MAST    = 3'd0;
    localparam logic [2:0] REG_INSTANT = 3'd4;

    typedef enum logic { KIND_TICK = 1'b0, KIND_LOAD = 1'b1 } item_kind_e;

endpackage

// File: test/tb_pts_checker.sv
// checker for pan_tilt_stepped_slew: watches apb writes and both streams,
// predicts each result and compares it; depends on tb_pts_defs
`timescale 1ns / 100ps
module tb_pts_checker
    import tb_pts_defs::*;
(
    input  wire logic        clk,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic [0:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [63:0] m_tdata,
    output int               pending,
    output int               errors
);

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic [11:0] bearing;
        logic [16:0] elevation;
        logic [31:0] range_dm;
        logic        moved;
    } pose_t;

    localparam int ITERS = 24;
    localparam longint TAN_ONE = 64'sd1 << 30;

    longint atan_lut [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0};

    logic [13:0] mast_reg = 14'd1000;
    logic        instant_reg = 1'b0;
    logic [11:0] brg_now = 12'd0;
    logic [16:0] elev_now = 17'd250;
    pose_t       expected_poses [$];

    initial errors = 0;
    assign pending = expected_poses.size();

    function automatic longint asr_trunc(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -((-v) >>> s);
    endfunction

    function automatic longint mast_eff();
        return (mast_reg == 0) ? 64'd1 : longint'(mast_reg);
    endfunction

    function automatic logic [31:0] range_of(logic [16:0] e);
        longint x, y, z, xn, yn;
        longint unsigned num, den, r;
        x = TAN_ONE;
        y = 0;
        z = longint'(((u64_t'(e) << 32) + 180000) / 360000);
        for (int i = 0; i < ITERS; i++)
        begin
            if (z >= 0)
            begin
                xn = x - asr_trunc(y, i); yn = y + asr_trunc(x, i); z -= atan_lut[i];
            end
            else
            begin
                xn = x + asr_trunc(y, i); yn = y - asr_trunc(x, i); z += atan_lut[i];
            end
            x = xn; y = yn;
        end
        if (y <= 0)
            return 32'hFFFF_FFFF;
        if (x <= 0)
            return 32'd0;
        num = u64_t'(mast_eff()) * u64_t'(x);
        den = 10 * u64_t'(y);
        r = (num + den / 2) / den;
        return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    function automatic logic [16:0] elev_of(longint unsigned r);
        longint x, y, z, xn, yn;
        longint unsigned e;
        x = longint'(10 * r);
        y = mast_eff();
        z = 0;
        while (((x > y) ? x : y) < (64'sd1 << 40))
        begin
            x = x <<< 1; y = y <<< 1;
        end
        for (int i = 0; i < ITERS; i++)
        begin
            if (y > 0)
            begin
                xn = x + asr_trunc(y, i); yn = y - asr_trunc(x, i); z += atan_lut[i];
            end
            else
            begin
                xn = x - asr_trunc(y, i); yn = y + asr_trunc(x, i); z -= atan_lut[i];
            end
            x = xn; y = yn;
        end
        if (z < 0) z = 0;
        if (z > TAN_ONE) z = TAN_ONE;
        e = (u64_t'(z) * 360000 + (64'd1 << 31)) >> 32;
        if (e < 1) e = 1;
        if (e > 90000) e = 90000;
        return e[16:0];
    endfunction

    function automatic logic [11:0] slew_bearing(int unsigned cur, int unsigned tgt);
        int unsigned d1, d2, d, s;
        bit down;
        d1 = (tgt + 3600 - cur) % 3600;
        d2 = 3600 - d1;
        down = d1 > d2;
        d = down ? d2 : d1;
        if (d > 500) s = 100;
        else if (d > 250) s = 50;
        else if (d > 50) s = 10;
        else s = d;
        return down ? 12'((cur + 3600 - s) % 3600) : 12'((cur + s) % 3600);
    endfunction

    function automatic logic [16:0] slew_elevation(int unsigned cur, int unsigned tgt);
        int unsigned rr, ra, gap, s, ne;
        longint unsigned nr;
        if (tgt == cur)
            return 17'(cur);
        rr = range_of(17'(tgt));
        ra = range_of(17'(cur));
        gap = (rr > ra) ? rr - ra : ra - rr;
        if (gap > 5000) s = 1000;
        else if (gap > 1000) s = 100;
        else if (gap > 200) s = 20;
        else return 17'(tgt);
        nr = (rr > ra) ? u64_t'(ra) + s : u64_t'(ra) - s;
        ne = elev_of(nr);
        // no progress after rounding: creep one millidegree
        if (ne == cur) ne = (tgt > cur) ? cur + 1 : cur - 1;
        if (tgt > cur && ne > tgt) ne = tgt;
        if (tgt < cur && ne < tgt) ne = tgt;
        return 17'(ne);
    endfunction

    function automatic pose_t advance_pose(item_kind_e kind, logic [11:0] b_in,
                                           logic [16:0] e_in);
        pose_t p;
        logic [11:0] b, ob;
        logic [16:0] e, oe;
        b = (b_in >= 3600) ? b_in - 12'd3600 : b_in;
        e = (e_in < 1) ? 17'd1 : (e_in > 90000) ? 17'd90000 : e_in;
        ob = brg_now;
        oe = elev_now;
        if (kind == KIND_LOAD || instant_reg)
        begin
            brg_now = b;
            elev_now = e;
        end
        else
        begin
            brg_now = slew_bearing(ob, b);
            elev_now = slew_elevation(oe, e);
        end
        p.bearing = brg_now;
        p.elevation = elev_now;
        p.range_dm = range_of(elev_now);
        p.moved = (brg_now != ob) || (elev_now != oe);
        return p;
    endfunction

    always @(posedge clk)
    begin
        pose_t want, got;
        if (psel && penable && pwrite && pready)
        begin
            if (paddr == REG_MAST) mast_reg = pwdata[13:0];
            else if (paddr == REG_INSTANT) instant_reg = pwdata[0];
        end
        if (s_tvalid && s_tready)
            expected_poses.push_back(advance_pose(item_kind_e'(s_tuser[0]),
                                                  s_tdata[11:0], s_tdata[28:12]));
        if (m_tvalid && m_tready)
        begin
            got.bearing = m_tdata[11:0];
            got.elevation = m_tdata[28:12];
            got.range_dm = m_tdata[60:29];
            got.moved = m_tdata[61];
            if (expected_poses.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %h", $time, m_tdata);
            end
            else
            begin
                want = expected_poses.pop_front();
                if (got.bearing !== want.bearing)
                begin
                    errors++;
                    $display("%0t: bearing expected %0d actual %0d", $time,
                             want.bearing, got.bearing);
                end
                if (got.elevation !== want.elevation)
                begin
                    errors++;
                    $display("%0t: elevation expected %0d actual %0d", $time,
                             want.elevation, got.elevation);
                end
                if (got.range_dm !== want.range_dm)
                begin
                    errors++;
                    $display("%0t: range expected %0d actual %0d", $time,
                             want.range_dm, got.range_dm);
                end
                if (got.moved !== want.moved)
                begin
                    errors++;
                    $display("%0t: moved expected %0d actual %0d", $time,
                             want.moved, got.moved);
                end
            end
        end
    end

endmodule

// File: test/tb_pan_tilt_stepped_slew.sv
// top of the pan/tilt slew testbench: clock, reset, apb writes and stream stimulus
// depends on tb_pts_defs, tb_pts_checker and the block under test
`timescale 1ns / 100ps
module tb_pan_tilt_stepped_slew;
    import tb_pts_defs::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    int          pending;
    int          errors;

    bit          tx_gaps = 1'b1;
    bit          rx_gaps = 1'b1;
    bit          rx_hold_req = 1'b0;
    int          quiet_cycles = 0;
    logic [11:0] aim_brg;
    logic [16:0] aim_elev;

    pan_tilt_stepped_slew uut (.*);

    tb_pts_checker checker_i (.*);

    initial
    begin
        forever #2 clk = ~clk;
    end

    // receiver: random idling, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (1500) @(negedge clk);
                rx_hold_req = 1'b0;
            end
            m_tready <= !(rx_gaps && $urandom_range(99) < 38);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("pan_tilt_stepped_slew: mismatch");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send(item_kind_e kind, logic [11:0] brg, logic [16:0] elev);
        @(negedge clk);
        while (tx_gaps && $urandom_range(99) < 38)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {3'b0, elev, brg};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    function automatic logic [16:0] any_elev();
        case ($urandom_range(9))
            0: return 17'($urandom_range(131071));
            1: return 17'($urandom_range(200, 1));
            2: return 17'($urandom_range(90000, 85000));
            default: return 17'($urandom_range(90000, 1));
        endcase
    endfunction

    // mostly runs of ticks toward a held aim, with loads and noise mixed in
    task automatic random_items(int count);
        int u;
        for (int n = 0; n < count; n++)
        begin
            u = $urandom_range(99);
            if (u < 8)
            begin
                aim_brg = 12'($urandom_range(4095));
                aim_elev = any_elev();
            end
            if (u < 15)
                send(KIND_LOAD, 12'($urandom_range(4095)), any_elev());
            else if (u < 22)
                send(KIND_TICK, 12'($urandom_range(4095)), any_elev());
            else
                send(KIND_TICK, aim_brg, aim_elev);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: defaults, extremes, each bearing band, tie, both kinds
        send(KIND_TICK, 12'd0, 17'd250);
        send(KIND_LOAD, 12'd0, 17'd1);
        send(KIND_LOAD, 12'd3599, 17'd90000);
        send(KIND_LOAD, 12'd4095, 17'd131071);
        send(KIND_LOAD, 12'd3600, 17'd0);
        send(KIND_TICK, 12'd1800, 17'd45000);
        send(KIND_TICK, 12'd1800, 17'd45000);
        send(KIND_TICK, 12'd400, 17'd100);
        send(KIND_TICK, 12'd3500, 17'd1);
        send(KIND_TICK, 12'd3000, 17'd90000);
        send(KIND_TICK, 12'd2900, 17'd89990);
        send(KIND_TICK, 12'd2850, 17'd89000);
        send(KIND_TICK, 12'd2849, 17'd89000);
        send(KIND_LOAD, 12'd100, 17'd5000);
        send(KIND_TICK, 12'd110, 17'd5100);
        send(KIND_TICK, 12'd4000, 17'd5101);
        send(KIND_TICK, 12'd4000, 17'd0);
        send(KIND_TICK, 12'd0, 17'd131071);
        aim_brg = 12'd2000;
        aim_elev = 17'd30000;
        drain();

        reg_write(REG_MAST, 32'd10000);
        random_items(180);
        drain();

        // long hold-off on the result side while items keep coming
        reg_write(REG_MAST, 32'd1);
        rx_hold_req = 1'b1;
        random_items(180);
        drain();

        reg_write(REG_MAST, 32'd0);
        reg_write(REG_INSTANT, 32'd1);
        random_items(150);
        drain();

        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        reg_write(REG_MAST, 32'd16383);
        reg_write(REG_INSTANT, 32'd0);
        random_items(200);
        drain();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;

        reg_write(REG_MAST, 32'd1000);
        random_items(370);
        drain();

        if (errors == 0)
            $display("pan_tilt_stepped_slew: match");
        else
            $display("pan_tilt_stepped_slew: mismatch");
        $finish;
    end

endmodule
